// ===== design/fmhp_pkg.sv =====
// types and constants shared by the flac metadata header parser
// no dependencies; used by every module of the parser
`default_nettype none

package fmhp_pkg;

  typedef enum logic [1:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_NO_INFO = 3'd3;
  localparam logic [2:0] ST_BAD_FMT = 3'd4;

  localparam logic [7:0] MAGIC_0 = 8'h66;
  localparam logic [7:0] MAGIC_1 = 8'h4C;
  localparam logic [7:0] MAGIC_2 = 8'h61;
  localparam logic [7:0] MAGIC_3 = 8'h43;

  localparam logic [7:0] LAST_MASK = 8'h80;
  localparam logic [7:0] TYPE_MASK = 8'h7F;

  localparam logic [5:0] INFO_MIN_SIZE = 6'd34;
  localparam logic [3:0] MIN_BUFFER    = 4'd8;
  localparam logic [4:0] MIN_BITS_CODE = 5'd7;

  // classified request passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic [3:0] magic_eq;
    logic       last_flag;
    logic       type_zero;
  } item_t;

endpackage

`default_nettype wire

// ===== design/fmhp_front.sv =====
// front end: accepts input bytes and classifies them into queue requests
// depends on fmhp_pkg
`default_nettype none

module fmhp_front (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           in_end_of_buffer,
  output logic                push,
  output fmhp_pkg::item_t     push_item,
  input  wire logic           q_ready
);

  assign in_ready = q_ready;
  assign push     = in_valid & q_ready;

  always_comb begin
    push_item.data        = in_data_byte;
    push_item.eob         = in_end_of_buffer;
    push_item.magic_eq[0] = (in_data_byte == fmhp_pkg::MAGIC_0);
    push_item.magic_eq[1] = (in_data_byte == fmhp_pkg::MAGIC_1);
    push_item.magic_eq[2] = (in_data_byte == fmhp_pkg::MAGIC_2);
    push_item.magic_eq[3] = (in_data_byte == fmhp_pkg::MAGIC_3);
    push_item.last_flag   = (in_data_byte & fmhp_pkg::LAST_MASK) != 8'd0;
    push_item.type_zero   = (in_data_byte & fmhp_pkg::TYPE_MASK) == 8'd0;
  end

endmodule

`default_nettype wire

// ===== design/fmhp_queue.sv =====
// two-entry request queue between front and back
// depends on fmhp_pkg
`default_nettype none

module fmhp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire fmhp_pkg::item_t push_item,
  output logic                 q_ready,
  output logic                 q_valid,
  output fmhp_pkg::item_t      q_item,
  input  wire logic            pop
);

  fmhp_pkg::item_t entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;

  assign q_ready = (count_r != 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/fmhp_back.sv =====
// back end: walks magic, block headers and bodies, captures streaminfo fields
// and holds the result in an output register; depends on fmhp_pkg
`default_nettype none

module fmhp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire fmhp_pkg::item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           out_status,
  output logic [19:0]          out_stream_rate,
  output logic [3:0]           out_channel_count,
  output logic [5:0]           out_sample_bits,
  output logic [35:0]          out_stream_total,
  output logic [35:0]          out_output_length
);

  localparam logic [5:0] OFF_RATE_HI  = 6'd10;
  localparam logic [5:0] OFF_RATE_MID = 6'd11;
  localparam logic [5:0] OFF_RATE_LO  = 6'd12;
  localparam logic [5:0] OFF_BITS     = 6'd13;
  localparam logic [5:0] OFF_TOTAL_3  = 6'd14;
  localparam logic [5:0] OFF_TOTAL_2  = 6'd15;
  localparam logic [5:0] OFF_TOTAL_1  = 6'd16;
  localparam logic [5:0] OFF_TOTAL_0  = 6'd17;

  fmhp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic        magic_bad_r, magic_bad_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic        hdr_type_zero_r, hdr_type_zero_nxt;
  logic        last_r, last_nxt;
  logic        type_zero_r, type_zero_nxt;
  logic [23:0] left_r, left_nxt;
  logic [5:0]  body_off_r, body_off_nxt;
  logic        have_r, have_nxt;
  logic [19:0] rate_r, rate_nxt;
  logic [2:0]  chan_r, chan_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic [35:0] total_r, total_nxt;

  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [19:0] o_rate_r, o_rate_nxt;
  logic [3:0]  o_chan_r, o_chan_nxt;
  logic [5:0]  o_bits_r, o_bits_nxt;
  logic [35:0] o_total_r, o_total_nxt;
  logic [35:0] o_len_r, o_len_nxt;

  logic [7:0]  b;
  logic        finish;

  assign b      = q_item.data;
  assign pop    = q_valid && (!out_valid_r || out_ready);
  assign finish = pop && q_item.eob;

  // next state
  always_comb begin
    phase_nxt         = phase_r;
    seen_nxt          = seen_r;
    magic_bad_nxt     = magic_bad_r;
    hdr_idx_nxt       = hdr_idx_r;
    hdr_type_zero_nxt = hdr_type_zero_r;
    last_nxt          = last_r;
    type_zero_nxt     = type_zero_r;
    left_nxt          = left_r;
    body_off_nxt      = body_off_r;
    have_nxt          = have_r;
    rate_nxt          = rate_r;
    chan_nxt          = chan_r;
    bits_nxt          = bits_r;
    total_nxt         = total_r;

    if (seen_r < fmhp_pkg::MIN_BUFFER) begin
      seen_nxt = seen_r + 4'd1;
    end

    case (phase_r)
      fmhp_pkg::PH_MAGIC: begin
        if (!q_item.magic_eq[seen_r[1:0]]) begin
          magic_bad_nxt = 1'b1;
        end
        if (seen_r >= 4'd3) begin
          phase_nxt   = fmhp_pkg::PH_HEADER;
          hdr_idx_nxt = 2'd0;
        end
      end
      fmhp_pkg::PH_HEADER: begin
        if (hdr_idx_r == 2'd0) begin
          hdr_type_zero_nxt = q_item.type_zero;
          last_nxt          = q_item.last_flag;
          left_nxt          = 24'd0;
          hdr_idx_nxt       = 2'd1;
        end else begin
          left_nxt = {left_r[15:0], b};
          if (hdr_idx_r == 2'd3) begin
            type_zero_nxt = hdr_type_zero_r &&
                            (left_nxt >= {18'd0, fmhp_pkg::INFO_MIN_SIZE});
            body_off_nxt  = 6'd0;
            hdr_idx_nxt   = 2'd0;
            if (left_nxt == 24'd0) begin
              if (type_zero_nxt) begin
                have_nxt = 1'b1;
              end
              phase_nxt = last_r ? fmhp_pkg::PH_DONE : fmhp_pkg::PH_HEADER;
            end else begin
              phase_nxt = fmhp_pkg::PH_BODY;
            end
          end else begin
            hdr_idx_nxt = hdr_idx_r + 2'd1;
          end
        end
      end
      fmhp_pkg::PH_BODY: begin
        if (type_zero_r) begin
          case (body_off_r)
            OFF_RATE_HI:  rate_nxt = {b, rate_r[11:0]};
            OFF_RATE_MID: rate_nxt = {rate_r[19:12], b, rate_r[3:0]};
            OFF_RATE_LO: begin
              rate_nxt = {rate_r[19:4], b[7:4]};
              chan_nxt = b[3:1];
              bits_nxt = {b[0], bits_r[3:0]};
            end
            OFF_BITS: begin
              bits_nxt  = {bits_r[4], b[7:4]};
              total_nxt = {b[3:0], total_r[31:0]};
            end
            OFF_TOTAL_3: total_nxt = {total_r[35:32], b, total_r[23:0]};
            OFF_TOTAL_2: total_nxt = {total_r[35:24], b, total_r[15:0]};
            OFF_TOTAL_1: total_nxt = {total_r[35:16], b, total_r[7:0]};
            OFF_TOTAL_0: total_nxt = {total_r[35:8], b};
            default: ;
          endcase
        end
        if (body_off_r < fmhp_pkg::INFO_MIN_SIZE) begin
          body_off_nxt = body_off_r + 6'd1;
        end
        left_nxt = left_r - 24'd1;
        if (left_nxt == 24'd0) begin
          if (type_zero_r) begin
            have_nxt = 1'b1;
          end
          phase_nxt   = last_r ? fmhp_pkg::PH_DONE : fmhp_pkg::PH_HEADER;
          hdr_idx_nxt = 2'd0;
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    if (magic_bad_nxt || (seen_nxt < fmhp_pkg::MIN_BUFFER)) begin
      status_nxt = fmhp_pkg::ST_SHORT;
    end else if ((phase_nxt == fmhp_pkg::PH_BODY) && (left_nxt != 24'd0)) begin
      status_nxt = fmhp_pkg::ST_TRUNC;
    end else if (!have_nxt) begin
      status_nxt = fmhp_pkg::ST_NO_INFO;
    end else if ((bits_nxt < fmhp_pkg::MIN_BITS_CODE) || (rate_nxt == 20'd0)) begin
      status_nxt = fmhp_pkg::ST_BAD_FMT;
    end else begin
      status_nxt = fmhp_pkg::ST_OK;
    end

    o_rate_nxt  = 20'd0;
    o_chan_nxt  = 4'd0;
    o_bits_nxt  = 6'd0;
    o_total_nxt = 36'd0;
    o_len_nxt   = 36'd0;
    if (status_nxt == fmhp_pkg::ST_OK) begin
      o_rate_nxt  = rate_nxt;
      o_chan_nxt  = {1'b0, chan_nxt} + 4'd1;
      o_bits_nxt  = {1'b0, bits_nxt} + 6'd1;
      o_total_nxt = total_nxt;
      o_len_nxt   = (total_nxt == 36'd0) ? {18'd0, rate_nxt[19:2]} : total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      phase_r     <= fmhp_pkg::PH_MAGIC;
      seen_r      <= 4'd0;
      magic_bad_r <= 1'b0;
      hdr_idx_r   <= 2'd0;
      last_r      <= 1'b0;
      type_zero_r <= 1'b0;
      left_r      <= 24'd0;
      body_off_r  <= 6'd0;
      have_r      <= 1'b0;
    end else if (pop) begin
      phase_r     <= phase_nxt;
      seen_r      <= seen_nxt;
      magic_bad_r <= magic_bad_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      last_r      <= last_nxt;
      type_zero_r <= type_zero_nxt;
      left_r      <= left_nxt;
      body_off_r  <= body_off_nxt;
      have_r      <= have_nxt;
    end
  end

  // captured fields only count once a full block sets have_r
  always_ff @(posedge clk) begin
    if (pop) begin
      hdr_type_zero_r <= hdr_type_zero_nxt;
      rate_r          <= rate_nxt;
      chan_r          <= chan_nxt;
      bits_r          <= bits_nxt;
      total_r         <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status_r  <= status_nxt;
      o_rate_r  <= o_rate_nxt;
      o_chan_r  <= o_chan_nxt;
      o_bits_r  <= o_bits_nxt;
      o_total_r <= o_total_nxt;
      o_len_r   <= o_len_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_stream_rate   = o_rate_r;
  assign out_channel_count = o_chan_r;
  assign out_sample_bits   = o_bits_r;
  assign out_stream_total  = o_total_r;
  assign out_output_length = o_len_r;

endmodule

`default_nettype wire

// ===== design/flac_metadata_header_parser.sv =====
// FLAC metadata header parser, one buffer byte per cycle. A byte is taken in
// every cycle while the two-entry queue behind the input has room; the parser
// behind it retires one byte a cycle and only stalls while its single result
// register is full and not being taken. The byte flagged end_of_buffer yields
// one result (status, streaminfo fields and output length) once it has passed
// through the queue and been registered in the result register, and the parser
// then starts fresh on the next buffer with no gap.
// Depends on fmhp_pkg, fmhp_front, fmhp_queue and fmhp_back.
`default_nettype none

module flac_metadata_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [19:0]      out_stream_rate,
  output logic [3:0]       out_channel_count,
  output logic [5:0]       out_sample_bits,
  output logic [35:0]      out_stream_total,
  output logic [35:0]      out_output_length
);

  logic            push;
  fmhp_pkg::item_t push_item;
  logic            q_ready;
  logic            q_valid;
  fmhp_pkg::item_t q_item;
  logic            pop;

  fmhp_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .push             (push),
    .push_item        (push_item),
    .q_ready          (q_ready)
  );

  fmhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  fmhp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_stream_rate   (out_stream_rate),
    .out_channel_count (out_channel_count),
    .out_sample_bits   (out_sample_bits),
    .out_stream_total  (out_stream_total),
    .out_output_length (out_output_length)
  );

endmodule

`default_nettype wire
